// ===== design/rkx_pkg.sv =====
`default_nettype none
package rkx_pkg;

	localparam int IV_BYTES = 128;
	localparam int PW_BYTES = 32;
	localparam int IV_AW = (IV_BYTES > 1) ? $clog2(IV_BYTES) : 1;
	localparam int PW_AW = (PW_BYTES > 1) ? $clog2(PW_BYTES) : 1;

	localparam int OPC_W = 2;
	localparam int IDX_W = 7;
	localparam int BYTE_W = 8;
	localparam int PLEN_W = 6;
	localparam int CFG_IW = 1;
	localparam int CFG_DW = 6;

	localparam logic [OPC_W-1:0] OP_DATA = 2'd0;
	localparam logic [OPC_W-1:0] OP_IV_LOAD = 2'd1;
	localparam logic [OPC_W-1:0] OP_PW_LOAD = 2'd2;

	localparam logic [CFG_IW-1:0] REG_MODE = 1'b0;
	localparam logic [CFG_IW-1:0] REG_PLEN = 1'b1;

	localparam int QDEPTH = 4;
	localparam int QAW = 2;
	localparam int OUT_DEPTH = 4;
	localparam int OUT_AW = 2;

	typedef enum logic [1:0] {
		CMD_DATA,
		CMD_IV_WR,
		CMD_PW_WR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [IV_AW-1:0]   iv_addr;
		logic [PW_AW-1:0]   pw_addr;
		logic               use_iv;
		logic               use_pw;
		logic [BYTE_W-1:0]  data;
		logic               last;
	} cmd_t;

endpackage
`default_nettype wire

// ===== design/rotating_key_xor_obfuscator.sv =====
// A data request passes the command queue, the stage-1 registers and the result buffer.
// Throughput: one request per cycle unless full; table loads take a slot, no result.
// The rate is set by the single-port IV and password tables, one access per cycle.
// Up to four results buffer on the output; push sees full once the command queue fills.
// Reset (arst_n low) clears config, positions and the table valid bits: tables read zero.
`default_nettype none
module rotating_key_xor_obfuscator import rkx_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire logic [OPC_W-1:0]    opcode,
	input  wire logic [IDX_W-1:0]    table_index,
	input  wire logic [BYTE_W-1:0]   data_byte,
	input  wire logic                restart,
	input  wire logic                end_of_buffer,
	output logic                     empty,
	input  wire logic                pop,
	output logic [BYTE_W-1:0]        result_byte,
	output logic                     result_last,
	input  wire logic                cfg_write,
	input  wire logic [CFG_IW-1:0]   cfg_index,
	input  wire logic [CFG_DW-1:0]   cfg_data
);

	cmd_t  fq_cmd, qb_cmd;
	logic  fq_push, q_empty, q_pop;

	rkx_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.opcode        (opcode),
		.table_index   (table_index),
		.data_byte     (data_byte),
		.restart       (restart),
		.end_of_buffer (end_of_buffer),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.q_full        (full),
		.q_push        (fq_push),
		.q_cmd         (fq_cmd)
	);

	rkx_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (fq_push),
		.wr_cmd (fq_cmd),
		.full   (full),
		.rd_en  (q_pop),
		.rd_cmd (qb_cmd),
		.empty  (q_empty)
	);

	rkx_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_cmd       (qb_cmd),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.result_byte (result_byte),
		.result_last (result_last)
	);

endmodule
`default_nettype wire

// ===== design/rkx_front.sv =====
`default_nettype none
module rkx_front import rkx_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire logic [OPC_W-1:0]    opcode,
	input  wire logic [IDX_W-1:0]    table_index,
	input  wire logic [BYTE_W-1:0]   data_byte,
	input  wire logic                restart,
	input  wire logic                end_of_buffer,
	input  wire logic                cfg_write,
	input  wire logic [CFG_IW-1:0]   cfg_index,
	input  wire logic [CFG_DW-1:0]   cfg_data,
	input  wire logic                q_full,
	output logic                     q_push,
	output cmd_t                     q_cmd
);

	logic               mode_q;
	logic [PLEN_W-1:0]  plen_q;
	logic [IV_AW-1:0]   iv_pos_q;
	logic [PW_AW-1:0]   pw_pos_q;

	logic               accept;
	logic [PLEN_W-1:0]  plen_eff;
	logic [IV_AW-1:0]   ip_base, ip_rd;
	logic [IV_AW:0]     ip_inc;
	logic [IV_AW-1:0]   ip_nx;
	logic [PW_AW-1:0]   pp_base, pp_rd;
	logic [PLEN_W-1:0]  pp_inc;
	logic [PW_AW-1:0]   pp_nx;
	logic               data_req;

	assign accept = push && !q_full;

	always_comb begin
		plen_eff = (plen_q > PLEN_W'(PW_BYTES)) ? PLEN_W'(PW_BYTES) : plen_q;

		ip_base = restart ? '0 : iv_pos_q;
		ip_rd = ((IV_AW+1)'(ip_base) >= (IV_AW+1)'(IV_BYTES)) ? '0 : ip_base;
		ip_inc = (IV_AW+1)'(ip_rd) + (IV_AW+1)'(1);
		ip_nx = (ip_inc >= (IV_AW+1)'(IV_BYTES)) ? '0 : ip_inc[IV_AW-1:0];

		pp_base = restart ? '0 : pw_pos_q;
		pp_rd = (PLEN_W'(pp_base) >= plen_eff) ? '0 : pp_base;
		pp_inc = PLEN_W'(pp_rd) + PLEN_W'(1);
		pp_nx = (pp_inc >= plen_eff) ? '0 : pp_inc[PW_AW-1:0];
	end

	always_comb begin
		q_push = 1'b0;
		data_req = 1'b0;
		q_cmd.kind = CMD_DATA;
		q_cmd.iv_addr = ip_rd;
		q_cmd.pw_addr = pp_rd;
		q_cmd.use_iv = mode_q;
		q_cmd.use_pw = mode_q && (plen_eff != '0);
		q_cmd.data = data_byte;
		q_cmd.last = end_of_buffer;
		case (opcode)
			OP_DATA: begin
				q_push = accept;
				data_req = accept;
			end
			OP_IV_LOAD: begin
				q_cmd.kind = CMD_IV_WR;
				q_cmd.iv_addr = table_index[IV_AW-1:0];
				q_push = accept && (int'(table_index) < IV_BYTES);
			end
			OP_PW_LOAD: begin
				q_cmd.kind = CMD_PW_WR;
				q_cmd.pw_addr = table_index[PW_AW-1:0];
				q_push = accept && (int'(table_index) < PW_BYTES);
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			plen_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_MODE: mode_q <= cfg_data[0];
				REG_PLEN: plen_q <= cfg_data[PLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// positions only move in cipher mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iv_pos_q <= '0;
			pw_pos_q <= '0;
		end else if (data_req && mode_q) begin
			iv_pos_q <= ip_nx;
			pw_pos_q <= (plen_eff == '0) ? '0 : pp_nx;
		end
	end

endmodule
`default_nettype wire

// ===== design/rkx_queue.sv =====
`default_nettype none
module rkx_queue import rkx_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   wr_en,
	input  wire cmd_t   wr_cmd,
	output logic        full,
	input  wire logic   rd_en,
	output cmd_t        rd_cmd,
	output logic        empty
);

	cmd_t             entry_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QAW:0]     cnt_q;
	logic             do_wr, do_rd;

	assign full = (cnt_q == (QAW+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + QAW'(1);
			if (do_rd) rd_ptr_q <= rd_ptr_q + QAW'(1);
			case ({do_wr, do_rd})
				2'b10: cnt_q <= cnt_q + (QAW+1)'(1);
				2'b01: cnt_q <= cnt_q - (QAW+1)'(1);
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/rkx_back.sv =====
`default_nettype none
module rkx_back import rkx_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cmd_t                q_cmd,
	input  wire logic                q_empty,
	output logic                     q_pop,
	output logic                     empty,
	input  wire logic                pop,
	output logic [BYTE_W-1:0]        result_byte,
	output logic                     result_last
);

	logic [BYTE_W-1:0]  iv_mem [IV_BYTES];
	logic [BYTE_W-1:0]  pw_mem [PW_BYTES];
	logic [IV_BYTES-1:0] iv_vld_q;
	logic [PW_BYTES-1:0] pw_vld_q;

	logic               s1_v_q;
	logic [BYTE_W-1:0]  iv_rd_s1, pw_rd_s1, data_s1;
	logic               iv_hit_s1, pw_hit_s1, use_iv_s1, use_pw_s1, last_s1;
	logic [BYTE_W-1:0]  xor_s1;

	logic [BYTE_W-1:0]  ob_byte_q [OUT_DEPTH];
	logic               ob_last_q [OUT_DEPTH];
	logic [OUT_AW-1:0]  ob_wr_q, ob_rd_q;
	logic [OUT_AW:0]    ob_cnt_q;
	logic               ob_pop;
	logic               rd_data;

	// credit: room for the stage-1 item plus the one popped now
	assign q_pop = !q_empty &&
		((OUT_AW+1)'(ob_cnt_q) + (OUT_AW+1)'(s1_v_q) < (OUT_AW+1)'(OUT_DEPTH));
	assign rd_data = q_pop && (q_cmd.kind == CMD_DATA);

	always_ff @(posedge clk) begin
		if (q_pop && q_cmd.kind == CMD_IV_WR) begin
			iv_mem[q_cmd.iv_addr] <= q_cmd.data;
		end
		if (rd_data) begin
			iv_rd_s1 <= iv_mem[q_cmd.iv_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_cmd.kind == CMD_PW_WR) begin
			pw_mem[q_cmd.pw_addr] <= q_cmd.data;
		end
		if (rd_data) begin
			pw_rd_s1 <= pw_mem[q_cmd.pw_addr];
		end
	end

	// unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iv_vld_q <= '0;
			pw_vld_q <= '0;
		end else if (q_pop) begin
			if (q_cmd.kind == CMD_IV_WR) iv_vld_q[q_cmd.iv_addr] <= 1'b1;
			if (q_cmd.kind == CMD_PW_WR) pw_vld_q[q_cmd.pw_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_data) begin
			data_s1 <= q_cmd.data;
			last_s1 <= q_cmd.last;
			use_iv_s1 <= q_cmd.use_iv;
			use_pw_s1 <= q_cmd.use_pw;
			iv_hit_s1 <= iv_vld_q[q_cmd.iv_addr];
			pw_hit_s1 <= pw_vld_q[q_cmd.pw_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else begin
			s1_v_q <= rd_data;
		end
	end

	assign xor_s1 = data_s1
		^ ((use_iv_s1 && iv_hit_s1) ? iv_rd_s1 : '0)
		^ ((use_pw_s1 && pw_hit_s1) ? pw_rd_s1 : '0);

	assign empty = (ob_cnt_q == '0);
	assign ob_pop = pop && !empty;
	assign result_byte = ob_byte_q[ob_rd_q];
	assign result_last = ob_last_q[ob_rd_q];

	always_ff @(posedge clk) begin
		if (s1_v_q) begin
			ob_byte_q[ob_wr_q] <= xor_s1;
			ob_last_q[ob_wr_q] <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_wr_q <= '0;
			ob_rd_q <= '0;
			ob_cnt_q <= '0;
		end else begin
			if (s1_v_q) ob_wr_q <= ob_wr_q + OUT_AW'(1);
			if (ob_pop) ob_rd_q <= ob_rd_q + OUT_AW'(1);
			case ({s1_v_q, ob_pop})
				2'b10: ob_cnt_q <= ob_cnt_q + (OUT_AW+1)'(1);
				2'b01: ob_cnt_q <= ob_cnt_q - (OUT_AW+1)'(1);
				default: ;
			endcase
		end
	end

	a_ob_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ob_cnt_q <= (OUT_AW+1)'(OUT_DEPTH))
		else $error("result buffer count out of range");

	a_s1_room: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_q |-> ob_cnt_q < (OUT_AW+1)'(OUT_DEPTH))
		else $error("stage-1 result has no buffer slot");

	a_data_flow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_data |=> s1_v_q)
		else $error("data request lost after table read");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty command queue");

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none
module tb;
	import rkx_pkg::*;

	// opcode with no meaning: the block drops it
	localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 3000;
	localparam int LONG_HOLD = 90;
	localparam int PHASES = 13;
	localparam int PHASE_REQS = 150;

	typedef struct {
		logic [OPC_W-1:0]  op;
		logic [IDX_W-1:0]  idx;
		logic [BYTE_W-1:0] data;
		logic              restart;
		logic              last;
	} req_t;

	typedef struct {
		logic [BYTE_W-1:0] value;
		logic              last;
	} cipher_out_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                push = 1'b0;
	logic [OPC_W-1:0]    opcode = OP_DATA;
	logic [IDX_W-1:0]    table_index = '0;
	logic [BYTE_W-1:0]   data_byte = '0;
	logic                restart = 1'b0;
	logic                end_of_buffer = 1'b0;
	logic                pop = 1'b0;
	logic                cfg_write = 1'b0;
	logic [CFG_IW-1:0]   cfg_index = REG_MODE;
	logic [CFG_DW-1:0]   cfg_data = '0;
	wire logic           full;
	wire logic           empty;
	wire logic [BYTE_W-1:0] result_byte;
	wire logic           result_last;

	rotating_key_xor_obfuscator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.opcode(opcode),
		.table_index(table_index),
		.data_byte(data_byte),
		.restart(restart),
		.end_of_buffer(end_of_buffer),
		.empty(empty),
		.pop(pop),
		.result_byte(result_byte),
		.result_last(result_last),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	logic [BYTE_W-1:0] iv_key [IV_BYTES];
	logic [BYTE_W-1:0] pw_key [PW_BYTES];
	int                iv_ptr = 0;
	int                pw_ptr = 0;
	logic              mode_r = 1'b0;
	logic [PLEN_W-1:0] plen_r = '0;

	req_t        pending_reqs[$];
	cipher_out_t expected_bytes[$];
	req_t        cur_req;
	int          mismatches = 0;
	int          tx_gap = 0;
	int          rx_gap = 0;
	int          rx_hold = 0;
	int          hold_req = 0;
	int          hold_seen = 0;
	int          stall_cycles = 0;
	bit          quiet = 1'b0;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic void predict_cipher(input req_t r);
		int ip, pp, n;
		cipher_out_t o;
		case (r.op)
			OP_IV_LOAD: begin
				if (r.idx < IV_BYTES) iv_key[r.idx] = r.data;
			end
			OP_PW_LOAD: begin
				if (r.idx < PW_BYTES) pw_key[r.idx[PW_AW-1:0]] = r.data;
			end
			OP_DATA: begin
				o.value = r.data;
				o.last = r.last;
				if (mode_r) begin
					ip = r.restart ? 0 : iv_ptr;
					pp = r.restart ? 0 : pw_ptr;
					n = (plen_r > PW_BYTES) ? PW_BYTES : int'(plen_r);
					if (ip >= IV_BYTES) ip = 0;
					o.value ^= iv_key[ip];
					ip++;
					if (ip >= IV_BYTES) ip = 0;
					iv_ptr = ip;
					if (n == 0) begin
						pw_ptr = 0;
					end else begin
						// a shorter length can leave the position past the end
						if (pp >= n) pp = 0;
						o.value ^= pw_key[pp];
						pp++;
						if (pp >= n) pp = 0;
						pw_ptr = pp;
					end
				end
				expected_bytes.push_back(o);
			end
			default: ;
		endcase
	endfunction

	function automatic void queue_req(input logic [OPC_W-1:0] op, input int idx,
			input int data, input logic rs, input logic last);
		req_t r;
		r.op = op;
		r.idx = idx[IDX_W-1:0];
		r.data = data[BYTE_W-1:0];
		r.restart = rs;
		r.last = last;
		pending_reqs.push_back(r);
	endfunction

	function automatic req_t random_req();
		req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		r.idx = IDX_W'($urandom_range(0, 127));
		r.data = BYTE_W'($urandom_range(0, 255));
		r.restart = ($urandom_range(0, 15) == 0);
		r.last = ($urandom_range(0, 7) == 0);
		if (pick < 62) begin
			r.op = OP_DATA;
		end else if (pick < 78) begin
			r.op = OP_IV_LOAD;
		end else if (pick < 96) begin
			r.op = OP_PW_LOAD;
			if ($urandom_range(0, 4) != 0) r.idx = IDX_W'($urandom_range(0, PW_BYTES - 1));
		end else begin
			r.op = OP_UNUSED;
		end
		return r;
	endfunction

	task automatic set_config(input logic m, input int n);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= REG_MODE;
		cfg_data <= {{(CFG_DW-1){1'b0}}, m};
		@(posedge clk);
		cfg_index <= REG_PLEN;
		cfg_data <= CFG_DW'(n);
		@(posedge clk);
		cfg_write <= 1'b0;
		mode_r = m;
		plen_r = PLEN_W'(n);
	endtask

	// loads give no result, so wait on past the last expected result for the pipeline to drain
	task automatic settle();
		while (pending_reqs.size() != 0 || push || expected_bytes.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	// sender
	always @(posedge clk) begin
		logic busy;
		busy = push;
		if (push && !full) begin
			predict_cipher(cur_req);
			busy = 1'b0;
			if (!quiet && $urandom_range(0, 9) == 0) tx_gap = $urandom_range(1, 13);
		end
		if (!busy) begin
			if (tx_gap > 0) begin
				tx_gap--;
				push <= 1'b0;
			end else if (arst_n && pending_reqs.size() != 0) begin
				cur_req = pending_reqs.pop_front();
				push <= 1'b1;
				opcode <= cur_req.op;
				table_index <= cur_req.idx;
				data_byte <= cur_req.data;
				restart <= cur_req.restart;
				end_of_buffer <= cur_req.last;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		cipher_out_t e;
		if (pop && !empty) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected result: result_byte %02h result_last %0b",
					$time, result_byte, result_last);
				mismatches++;
			end else begin
				e = expected_bytes.pop_front();
				if (result_byte !== e.value) begin
					$display("%0t: result_byte expected %02h, got %02h",
						$time, e.value, result_byte);
					mismatches++;
				end
				if (result_last !== e.last) begin
					$display("%0t: result_last expected %0b, got %0b",
						$time, e.last, result_last);
					mismatches++;
				end
			end
		end
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			rx_hold = LONG_HOLD;
		end
		if (rx_hold > 0) begin
			rx_hold--;
			pop <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
			if (!quiet && $urandom_range(0, 9) == 0) rx_gap = $urandom_range(1, 13);
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		int plen_pick[8];
		req_t r;
		int n;
		plen_pick = '{0, 1, 2, 7, 31, 32, 33, 63};
		foreach (iv_key[i]) iv_key[i] = '0;
		foreach (pw_key[i]) pw_key[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// pass-through from reset, table loads, ignored loads and opcode
		queue_req(OP_DATA, 0, 'h00, 1'b0, 1'b0);
		queue_req(OP_DATA, 127, 'hFF, 1'b1, 1'b1);
		queue_req(OP_IV_LOAD, 0, 'hA5, 1'b0, 1'b0);
		queue_req(OP_IV_LOAD, 127, 'h3C, 1'b1, 1'b1);
		queue_req(OP_PW_LOAD, 0, 'h5A, 1'b0, 1'b0);
		queue_req(OP_PW_LOAD, 31, 'hC3, 1'b0, 1'b1);
		queue_req(OP_PW_LOAD, 32, 'hFF, 1'b0, 1'b0);
		queue_req(OP_PW_LOAD, 127, 'h11, 1'b1, 1'b0);
		queue_req(OP_UNUSED, 5, 'h77, 1'b1, 1'b1);
		queue_req(OP_DATA, 0, 'h81, 1'b0, 1'b1);
		settle();

		// zero password length: IV only, unloaded entries read zero
		set_config(1'b1, 0);
		queue_req(OP_DATA, 0, 'h00, 1'b1, 1'b0);
		queue_req(OP_DATA, 0, 'hFF, 1'b0, 1'b0);
		settle();

		set_config(1'b1, 32);
		queue_req(OP_DATA, 0, 'h00, 1'b1, 1'b0);
		queue_req(OP_DATA, 0, 'h12, 1'b0, 1'b0);
		queue_req(OP_DATA, 0, 'h34, 1'b0, 1'b0);
		queue_req(OP_DATA, 0, 'h56, 1'b0, 1'b1);
		settle();

		// shrink below the current password position
		set_config(1'b1, 1);
		queue_req(OP_DATA, 0, 'hF0, 1'b0, 1'b1);
		settle();

		// length above the table size
		set_config(1'b1, 63);
		queue_req(OP_DATA, 0, 'h0F, 1'b1, 1'b0);
		queue_req(OP_DATA, 0, 'h55, 1'b0, 1'b1);
		settle();

		for (int ph = 0; ph < PHASES; ph++) begin
			set_config((ph == 3) ? 1'b0 : 1'b1,
				(ph < 8) ? plen_pick[ph] : int'($urandom_range(0, 63)));
			if (ph == PHASES - 1) quiet = 1'b1;
			if (ph == 5) hold_req++;
			n = 0;
			while (n < PHASE_REQS) begin
				r = random_req();
				pending_reqs.push_back(r);
				n++;
			end
			settle();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_bytes.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
`default_nettype wire
